// ----- design/c3zp_pkg.sv -----
// shared constants, register codes and types of the 3x3 convolution stream
package c3zp_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int COEF_BITS      = 16;
    localparam int OUT_BITS       = 35;
    localparam int CFG_BITS       = 48;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int CFG_INDEX_BITS = 3;

    localparam int FIFO_DEPTH     = 8;
    localparam int PTR_BITS       = $clog2(FIFO_DEPTH);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_LOW  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_MID  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW_HIGH = 3'd4;

    // reset values
    localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 13'd768;
    localparam logic [CFG_BITS-1:0]    RST_COEF_LOW     = 48'd0;
    localparam logic [CFG_BITS-1:0]    RST_COEF_MID     = 48'd65536;
    localparam logic [CFG_BITS-1:0]    RST_COEF_HIGH    = 48'd0;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    // sideband that travels with a window through the multiply pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] filtered;
        logic                last;
    } out_word_t;

endpackage

// ----- design/c3zp_line_buf.sv -----
// two line stores with registered read and write-to-read forwarding
module c3zp_line_buf #(
    parameter int DEPTH     = c3zp_pkg::DEF_MAX_WIDTH,
    parameter int DATA_BITS = c3zp_pkg::DEF_PIXEL_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_upper,
    input  logic [DATA_BITS-1:0]     wr_lower,
    output logic [DATA_BITS-1:0]     rd_upper,
    output logic [DATA_BITS-1:0]     rd_lower
);
    import c3zp_pkg::*;

    logic [DATA_BITS-1:0] upper_mem [DEPTH];
    logic [DATA_BITS-1:0] lower_mem [DEPTH];

    logic [DATA_BITS-1:0] upper_q_reg;
    logic [DATA_BITS-1:0] lower_q_reg;
    logic [DATA_BITS-1:0] fwd_upper_reg;
    logic [DATA_BITS-1:0] fwd_lower_reg;
    logic                 fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr] <= wr_upper;
            lower_mem[wr_addr] <= wr_lower;
        end
        if (rd_en) begin
            upper_q_reg   <= upper_mem[rd_addr];
            lower_q_reg   <= lower_mem[rd_addr];
            fwd_upper_reg <= wr_upper;
            fwd_lower_reg <= wr_lower;
        end
    end

    // read and write of the same column in one cycle: take the word being written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_upper = fwd_reg ? fwd_upper_reg : upper_q_reg;
    assign rd_lower = fwd_reg ? fwd_lower_reg : lower_q_reg;

endmodule

// ----- design/c3zp_mac.sv -----
// pipelined nine-tap multiply and adder tree
module c3zp_mac #(
    parameter int PIXEL_BITS = c3zp_pkg::DEF_PIXEL_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  c3zp_pkg::tag_t                in_tag,
    input  logic [PIXEL_BITS-1:0]         win [9],
    input  logic [c3zp_pkg::CFG_BITS-1:0] coef_low,
    input  logic [c3zp_pkg::CFG_BITS-1:0] coef_mid,
    input  logic [c3zp_pkg::CFG_BITS-1:0] coef_high,
    output c3zp_pkg::tag_t                out_tag,
    output logic [c3zp_pkg::OUT_BITS-1:0] out_sum,
    output logic [1:0]                    pending
);
    import c3zp_pkg::*;

    localparam int PROD_BITS = COEF_BITS + PIXEL_BITS;
    localparam int PART_BITS = PROD_BITS + 2;
    localparam int SUM_BITS  = PROD_BITS + 4;

    coef_t k [9];

    logic signed [PIXEL_BITS-1:0] win_reg  [9];
    logic signed [PROD_BITS-1:0]  prod_next [9];
    logic signed [PROD_BITS-1:0]  prod_reg  [9];
    logic signed [PART_BITS-1:0]  part_next [3];
    logic signed [PART_BITS-1:0]  part_reg  [3];
    logic signed [SUM_BITS-1:0]   sum;

    tag_t tag_a_reg, tag_b_reg, tag_c_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            k[j]     = coef_low[j*COEF_BITS +: COEF_BITS];
            k[3 + j] = coef_mid[j*COEF_BITS +: COEF_BITS];
            k[6 + j] = coef_high[j*COEF_BITS +: COEF_BITS];
        end
    end

    // tap i meets coefficient 8-i: the kernel is flipped
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            prod_next[i] = PROD_BITS'(k[8 - i]) * PROD_BITS'(win_reg[i]);
        end
        for (int g = 0; g < 3; g++) begin
            part_next[g] = PART_BITS'(prod_reg[3*g]) + PART_BITS'(prod_reg[3*g + 1])
                         + PART_BITS'(prod_reg[3*g + 2]);
        end
        sum = SUM_BITS'(part_reg[0]) + SUM_BITS'(part_reg[1]) + SUM_BITS'(part_reg[2]);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 9; i++) begin
            win_reg[i]  <= win[i];
            prod_reg[i] <= prod_next[i];
        end
        for (int g = 0; g < 3; g++) begin
            part_reg[g] <= part_next[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end else begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    assign out_tag = tag_c_reg;
    assign out_sum = OUT_BITS'(sum);
    assign pending = 2'(tag_a_reg.valid) + 2'(tag_b_reg.valid) + 2'(tag_c_reg.valid);

endmodule

// ----- design/c3zp_out_fifo.sv -----
// small output queue that parts the pipeline from the result channel
module c3zp_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  c3zp_pkg::out_word_t           push_word,
    input  logic                          pop,
    output logic                          valid,
    output c3zp_pkg::out_word_t           head,
    output logic [c3zp_pkg::PTR_BITS:0]   count
);
    import c3zp_pkg::*;

    out_word_t fifo_mem [FIFO_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;
    logic [PTR_BITS:0]   count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_word;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_BITS+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = fifo_mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ----- design/conv3x3_zero_padded_stream.sv -----
// top level of the zero-padded 3x3 convolution of a raster pixel stream
// Pixels enter in raster order, one word per cycle while s_ready is high, and each result
// is the flipped-kernel 3x3 weighted sum of its neighbourhood with pixels outside the
// image read as zero, given exact in signed Q35.0. The result for stream position o leaves
// when input o+W+1 is taken, so after a frame W+1 flush words (cmd = 1) drain the rest;
// the last result of a frame carries last_of_frame. The word rate is set by the two line
// stores, which give one read and one write per cycle; a column read right after it is
// written is served by forwarding. s_ready drops only when the eight-word output queue,
// counting results still in the multiply pipeline, is full. The line stores are never
// cleared: entries are masked by row, so no clearing pass follows reset. The user must
// write configuration with cfg_wr_en, cfg_index and cfg_wdata only while the block is
// idle; the block itself does not enforce this.
module conv3x3_zero_padded_stream #(
    parameter int MAX_WIDTH  = c3zp_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = c3zp_pkg::DEF_PIXEL_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic signed [PIXEL_BITS-1:0]         s_pixel,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [c3zp_pkg::OUT_BITS-1:0] m_filtered,
    output logic                                 m_last_of_frame,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [c3zp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [c3zp_pkg::CFG_BITS-1:0]        cfg_wdata
);
    import c3zp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);        // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);    // width, up to MAX_WIDTH itself
    localparam int XW = (WW > WIDTH_BITS) ? WW : WIDTH_BITS;
    localparam int HW = HEIGHT_BITS + 1;
    localparam int OW = PTR_BITS + 2;             // occupancy sum

    // configuration registers
    logic [WIDTH_BITS-1:0]  image_width_reg;
    logic [HEIGHT_BITS-1:0] image_height_reg;
    logic [CFG_BITS-1:0]    coef_low_reg;
    logic [CFG_BITS-1:0]    coef_mid_reg;
    logic [CFG_BITS-1:0]    coef_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            coef_low_reg     <= RST_COEF_LOW;
            coef_mid_reg     <= RST_COEF_MID;
            coef_high_reg    <= RST_COEF_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg  <= cfg_wdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg <= cfg_wdata[HEIGHT_BITS-1:0];
                REG_COEF_ROW_LOW:  coef_low_reg     <= cfg_wdata;
                REG_COEF_ROW_MID:  coef_mid_reg     <= cfg_wdata;
                REG_COEF_ROW_HIGH: coef_high_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective frame size: width held to 2..MAX_WIDTH, height to at least 2
    logic [XW-1:0]          width_ext;
    logic [WW-1:0]          width_eff;
    logic [HEIGHT_BITS-1:0] height_eff;
    logic [HW-1:0]          height_p1;
    logic [HW-1:0]          height_p2;

    always_comb begin
        width_ext = XW'(image_width_reg);
        if (width_ext < XW'(2)) begin
            width_eff = WW'(2);
        end else if (width_ext > XW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_ext);
        end
        height_eff = (image_height_reg < HEIGHT_BITS'(2)) ? HEIGHT_BITS'(2) : image_height_reg;
        height_p1  = HW'(height_eff) + HW'(1);
        height_p2  = HW'(height_eff) + HW'(2);
    end

    // input position
    logic [CW-1:0]          col_reg,  col_next;
    logic [HEIGHT_BITS-1:0] row_reg,  row_next;
    logic                   s_accept;

    logic                  col_zero;
    logic [HW-1:0]         row_ext;
    logic                  bot_ok, mid_ok, top_ok;
    logic                  emit, last;
    logic [PIXEL_BITS-1:0] bot;

    assign s_accept = s_valid && s_ready;

    always_comb begin
        col_zero = (col_reg == '0);
        row_ext  = HW'(row_reg);
        // rows beyond the frame and flush words read as zero
        bot_ok   = !s_cmd && (row_reg < height_eff);
        mid_ok   = (row_reg != '0) && (row_ext < height_p1);
        top_ok   = (row_reg >= HEIGHT_BITS'(2)) && (row_ext < height_p2);
        bot      = bot_ok ? s_pixel : '0;

        // column 0 closes the previous row, any other column gives the one before it
        if (col_zero) begin
            emit = (row_reg >= HEIGHT_BITS'(2));
            last = (row_ext == height_p1);
        end else begin
            emit = (row_reg != '0);
            last = (WW'(col_reg) == width_eff) && (row_reg == height_eff);
        end

        if (col_zero && (row_ext >= height_p1)) begin
            // frame drained, start the next one
            col_next = '0;
            row_next = '0;
        end else if ((WW'(col_reg) + WW'(1)) >= width_eff) begin
            col_next = '0;
            row_next = row_reg + HEIGHT_BITS'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line store data arrives, window shifts
    logic                  p1_valid_reg;
    logic                  p1_emit_reg;
    logic                  p1_last_reg;
    logic                  p1_col_zero_reg;
    logic                  p1_mid_ok_reg;
    logic                  p1_top_ok_reg;
    logic [CW-1:0]         p1_col_reg;
    logic [PIXEL_BITS-1:0] p1_bot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_emit_reg     <= emit;
            p1_last_reg     <= last;
            p1_col_zero_reg <= col_zero;
            p1_mid_ok_reg   <= mid_ok;
            p1_top_ok_reg   <= top_ok;
            p1_col_reg      <= col_reg;
            p1_bot_reg      <= bot;
        end
    end

    logic [PIXEL_BITS-1:0] rd_upper, rd_lower;

    // the lower row moves up unmasked, the new pixel becomes the lower row
    c3zp_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (col_reg),
        .wr_en    (p1_valid_reg),
        .wr_addr  (p1_col_reg),
        .wr_upper (rd_lower),
        .wr_lower (p1_bot_reg),
        .rd_upper (rd_upper),
        .rd_lower (rd_lower)
    );

    // taps[row*3+col], row 0 is the upper line, col 0 the oldest column
    logic [PIXEL_BITS-1:0] taps_reg [9];
    logic [PIXEL_BITS-1:0] taps_next [9];
    logic [PIXEL_BITS-1:0] new_col [3];
    logic [PIXEL_BITS-1:0] win [9];

    always_comb begin
        new_col[0] = p1_top_ok_reg ? rd_upper : '0;
        new_col[1] = p1_mid_ok_reg ? rd_lower : '0;
        new_col[2] = p1_bot_reg;
        for (int k = 0; k < 3; k++) begin
            // at column 0 the right-hand column of the closing window is padding
            win[3*k]     = taps_reg[3*k + 1];
            win[3*k + 1] = taps_reg[3*k + 2];
            win[3*k + 2] = p1_col_zero_reg ? '0 : new_col[k];
            taps_next[3*k]     = p1_col_zero_reg ? '0 : taps_reg[3*k + 1];
            taps_next[3*k + 1] = p1_col_zero_reg ? '0 : taps_reg[3*k + 2];
            taps_next[3*k + 2] = new_col[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                taps_reg[i] <= '0;
            end
        end else if (p1_valid_reg) begin
            for (int i = 0; i < 9; i++) begin
                taps_reg[i] <= taps_next[i];
            end
        end
    end

    // multiply pipeline
    tag_t                mac_in_tag;
    tag_t                mac_out_tag;
    logic [OUT_BITS-1:0] mac_sum;
    logic [1:0]          mac_pending;

    assign mac_in_tag.valid = p1_valid_reg && p1_emit_reg;
    assign mac_in_tag.last  = p1_last_reg;

    c3zp_mac #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tag    (mac_in_tag),
        .win       (win),
        .coef_low  (coef_low_reg),
        .coef_mid  (coef_mid_reg),
        .coef_high (coef_high_reg),
        .out_tag   (mac_out_tag),
        .out_sum   (mac_sum),
        .pending   (mac_pending)
    );

    // output queue
    out_word_t         push_word;
    out_word_t         head;
    logic              fifo_push;
    logic              m_pop;
    logic [PTR_BITS:0] fifo_count;
    logic [OW-1:0]     occupancy;

    assign fifo_push          = mac_out_tag.valid;
    assign push_word.filtered = mac_sum;
    assign push_word.last     = mac_out_tag.last;
    assign m_pop              = m_valid && m_ready;

    c3zp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_word (push_word),
        .pop       (m_pop),
        .valid     (m_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_filtered      = head.filtered;
    assign m_last_of_frame = head.last;

    // every result in flight has a queue slot reserved
    assign occupancy = OW'(fifo_count) + OW'(mac_pending) + OW'(mac_in_tag.valid);
    assign s_ready   = (occupancy < OW'(FIFO_DEPTH));

    // checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> (fifo_count < (PTR_BITS+1)'(FIFO_DEPTH)))
        else $error("output queue written while full");

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= OW'(FIFO_DEPTH))
        else $error("more results in flight than queue slots");

    a_credit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_ready && !m_pop) |=> !s_ready)
        else $error("queue slot freed without a word taken");

endmodule
